// ===== rtl/core/fcp_pkg.sv =====
package fcp_pkg;

	localparam int LIMIT_BITS  = 12;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd1022;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LOW   = 8'h20;
	localparam logic [7:0] CH_HIGH  = 8'h7E;

	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;

	localparam int NUM_CMDS   = 40;
	localparam int NAME_CHARS = 5;
	localparam logic [5:0] CMD_UNKNOWN = 6'd0;

	typedef enum logic [1:0] {
		PH_VERB,
		PH_PARAM,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_VERB_UNTERM,
		ST_PARAM_ERR
	} status_t;

	// fixed part of one queued result
	typedef struct packed {
		logic       is_verdict;
		logic       lookup;
		logic [7:0] ch;
		status_t    status;
	} fcp_item_t;

	// names padded with spaces, first character in the top byte
	localparam logic [8*NAME_CHARS-1:0] CMD_NAME [NUM_CMDS] = '{
		"ABOR ", "ACCT ", "ALLO ", "APPE ", "CWD  ", "CDUP ", "DELE ", "HELP ",
		"LIST ", "MKD  ", "MDTM ", "MODE ", "NLST ", "NOOP ", "PASS ", "PASV ",
		"PORT ", "PWD  ", "QUIT ", "RETR ", "RMD  ", "RNFR ", "RNTO ", "SITE ",
		"UMASK", "IDLE ", "CHMOD", "SIZE ", "STAT ", "STOR ", "STOU ", "STRU ",
		"SYST ", "TYPE ", "USER ", "XCUP ", "XCWD ", "XMKD ", "XPWD ", "XRMD "
	};

	localparam logic [2:0] CMD_LEN [NUM_CMDS] = '{
		3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd4, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
		3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
	};

endpackage

// ===== rtl/core/ftp_command_line_parser.sv =====
// FTP command line parser.
// Input channel (in_valid/in_ready): one packet byte per request, data_byte with
// end_of_packet marking the last byte. Output channel (out_valid/out_ready): one
// result per request, either a parameter character (is_verdict 0) or the line
// verdict with command_code, status and param_length. Bytes that cause no result
// (verb characters, the space, a pending CR, bytes after a verdict) are absorbed.
// Config channel (cfg_valid/cfg_ready): writes param_limit; always ready, and only
// to be used while the parser is idle.
// Throughput: one byte per cycle while the queue is not full. A front stage
// tracks the line and pushes result requests into a four-entry queue; a back
// stage does the command table match and holds the result in an output register.
// The queue entry is written at the edge that accepts a byte; the output register
// loads from the queue when that entry pops, and drives out_valid.
// When the receiver stalls, the output register holds and the queue fills; in_ready
// drops only once the queue is full.
// Reset: the parser returns to the start of a packet, the queue and output empty,
// param_limit back to 1022.
module ftp_command_line_parser import fcp_pkg::*; #(
	parameter int MAX_VERB_CHARS   = 5,
	parameter int PARAM_COUNT_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        end_of_packet,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        is_verdict,
	output logic [7:0]                  param_char,
	output logic [5:0]                  command_code,
	output logic [1:0]                  status,
	output logic [PARAM_COUNT_BITS-1:0] param_length,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [LIMIT_BITS-1:0]       param_limit
);

	localparam int VCW = $clog2(MAX_VERB_CHARS + 1);
	localparam int QW  = $bits(fcp_item_t) + PARAM_COUNT_BITS + 8 * MAX_VERB_CHARS + VCW + 1;

	logic [LIMIT_BITS-1:0]          limit_q;
	logic                           q_full, q_valid, push, pop;
	fcp_item_t                      f_item, b_item;
	logic [PARAM_COUNT_BITS-1:0]    f_len, b_len;
	logic [MAX_VERB_CHARS-1:0][7:0] f_verb, b_verb;
	logic [VCW-1:0]                 f_vcnt, b_vcnt;
	logic                           f_ovl, b_ovl;
	logic [QW-1:0]                  q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= param_limit;
		end
	end

	fcp_front #(
		.MAX_VERB_CHARS   (MAX_VERB_CHARS),
		.PARAM_COUNT_BITS (PARAM_COUNT_BITS),
		.VCW              (VCW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.param_limit   (limit_q),
		.q_full        (q_full),
		.push          (push),
		.item          (f_item),
		.len           (f_len),
		.verb          (f_verb),
		.vcnt          (f_vcnt),
		.ovl           (f_ovl)
	);

	assign q_wdata = {f_item, f_len, f_verb, f_vcnt, f_ovl};

	fcp_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_rdata),
		.pop    (pop)
	);

	assign {b_item, b_len, b_verb, b_vcnt, b_ovl} = q_rdata;

	fcp_back #(
		.MAX_VERB_CHARS   (MAX_VERB_CHARS),
		.PARAM_COUNT_BITS (PARAM_COUNT_BITS),
		.VCW              (VCW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.pop          (pop),
		.item         (b_item),
		.len          (b_len),
		.verb         (b_verb),
		.vcnt         (b_vcnt),
		.ovl          (b_ovl),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_verdict   (is_verdict),
		.param_char   (param_char),
		.command_code (command_code),
		.status       (status),
		.param_length (param_length)
	);

endmodule

// ===== rtl/core/fcp_front.sv =====
module fcp_front import fcp_pkg::*; #(
	parameter int MAX_VERB_CHARS   = 5,
	parameter int PARAM_COUNT_BITS = 12,
	parameter int VCW              = $clog2(MAX_VERB_CHARS + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            data_byte,
	input  logic                                  end_of_packet,
	input  logic [LIMIT_BITS-1:0]                 param_limit,
	input  logic                                  q_full,
	output logic                                  push,
	output fcp_item_t                             item,
	output logic [PARAM_COUNT_BITS-1:0]           len,
	output logic [MAX_VERB_CHARS-1:0][7:0]        verb,
	output logic [VCW-1:0]                        vcnt,
	output logic                                  ovl
);

	localparam int LW = (PARAM_COUNT_BITS > LIMIT_BITS) ? PARAM_COUNT_BITS : LIMIT_BITS;

	phase_t                               phase_q, phase_d;
	logic [MAX_VERB_CHARS-1:0][7:0]       verb_q, verb_d;
	logic [VCW-1:0]                       vcnt_q, vcnt_d;
	logic                                 ovl_q, ovl_d;
	logic                                 crp_q, crp_d;
	logic [PARAM_COUNT_BITS-1:0]          pcnt_q, pcnt_d;

	logic            accept;
	logic            is_cr, is_lf, is_sp, printable;
	logic [LW-1:0]   lim_ext, cnt_max, limit;
	logic            over_limit, bad_param, first_cr;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign is_cr     = (data_byte == CH_CR);
	assign is_lf     = (data_byte == CH_LF);
	assign is_sp     = (data_byte == CH_SPACE);
	assign printable = (data_byte >= CH_LOW) && (data_byte <= CH_HIGH);

	assign lim_ext    = LW'(param_limit);
	assign cnt_max    = LW'((32'd1 << PARAM_COUNT_BITS) - 32'd1);
	assign limit      = (lim_ext < cnt_max) ? lim_ext : cnt_max;
	assign over_limit = (LW'(pcnt_q) >= limit);
	assign bad_param  = end_of_packet || (!is_cr && (!printable || over_limit));
	assign first_cr   = !crp_q && (pcnt_q == '0) && is_cr;

	// next state
	always_comb begin
		logic line_end, new_pkt, app_cr, app_b;
		line_end = 1'b0;
		new_pkt  = 1'b0;
		app_cr   = 1'b0;
		app_b    = 1'b0;
		phase_d  = phase_q;
		verb_d   = verb_q;
		vcnt_d   = vcnt_q;
		ovl_d    = ovl_q;
		crp_d    = crp_q;
		pcnt_d   = pcnt_q;
		if (accept) begin
			unique case (phase_q)
				PH_VERB: begin
					if (crp_q && is_lf) begin
						line_end = 1'b1;
					end else if (end_of_packet) begin
						new_pkt = 1'b1;
					end else begin
						// a CR without LF becomes part of the verb
						app_cr = crp_q;
						crp_d  = 1'b0;
						if (is_sp) begin
							phase_d = PH_PARAM;
							pcnt_d  = '0;
						end else if (is_cr) begin
							crp_d = 1'b1;
						end else begin
							app_b = 1'b1;
						end
					end
				end
				PH_PARAM: begin
					if (first_cr || crp_q || bad_param) begin
						line_end = 1'b1;
					end else if (is_cr) begin
						crp_d = 1'b1;
					end else begin
						pcnt_d = pcnt_q + 1'b1;
					end
				end
				PH_DONE: begin
					new_pkt = end_of_packet;
				end
				default: begin
					new_pkt = 1'b1;
				end
			endcase
		end
		if (app_cr) begin
			if (vcnt_d < VCW'(MAX_VERB_CHARS)) begin
				for (int i = 0; i < MAX_VERB_CHARS; i++) begin
					if (VCW'(i) == vcnt_d) verb_d[i] = CH_CR;
				end
				vcnt_d = vcnt_d + 1'b1;
			end else begin
				ovl_d = 1'b1;
			end
		end
		if (app_b) begin
			if (vcnt_d < VCW'(MAX_VERB_CHARS)) begin
				for (int i = 0; i < MAX_VERB_CHARS; i++) begin
					if (VCW'(i) == vcnt_d) verb_d[i] = data_byte;
				end
				vcnt_d = vcnt_d + 1'b1;
			end else begin
				ovl_d = 1'b1;
			end
		end
		if (line_end) begin
			if (end_of_packet) begin
				new_pkt = 1'b1;
			end else begin
				phase_d = PH_DONE;
				crp_d   = 1'b0;
			end
		end
		if (new_pkt) begin
			phase_d = PH_VERB;
			vcnt_d  = '0;
			ovl_d   = 1'b0;
			crp_d   = 1'b0;
			pcnt_d  = '0;
		end
	end

	// queue request
	always_comb begin
		push            = 1'b0;
		item.is_verdict = 1'b1;
		item.lookup     = 1'b0;
		item.ch         = 8'h00;
		item.status     = ST_OK;
		len             = '0;
		if (accept) begin
			unique case (phase_q)
				PH_VERB: begin
					if (crp_q && is_lf) begin
						push        = 1'b1;
						item.lookup = 1'b1;
					end else if (end_of_packet) begin
						push        = 1'b1;
						item.status = ST_VERB_UNTERM;
					end
				end
				PH_PARAM: begin
					if (first_cr) begin
						push        = 1'b1;
						item.lookup = 1'b1;
					end else if (crp_q) begin
						push = 1'b1;
						len  = pcnt_q;
						if (is_lf) item.lookup = 1'b1;
						else       item.status = ST_PARAM_ERR;
					end else if (bad_param) begin
						push        = 1'b1;
						len         = pcnt_q;
						item.status = ST_PARAM_ERR;
					end else if (!is_cr) begin
						push            = 1'b1;
						item.is_verdict = 1'b0;
						item.ch         = data_byte;
						len             = pcnt_q + 1'b1;
					end
				end
				PH_DONE: begin
					push = 1'b0;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	assign verb = verb_q;
	assign vcnt = vcnt_q;
	assign ovl  = ovl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERB;
			vcnt_q  <= '0;
			ovl_q   <= 1'b0;
			crp_q   <= 1'b0;
			pcnt_q  <= '0;
		end else begin
			phase_q <= phase_d;
			vcnt_q  <= vcnt_d;
			ovl_q   <= ovl_d;
			crp_q   <= crp_d;
			pcnt_q  <= pcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		verb_q <= verb_d;
	end

`ifndef NO_ASSERTIONS
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> !push) else $error("request pushed after verdict");
	a_char_in_param: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !item.is_verdict) |-> (phase_q == PH_PARAM))
		else $error("parameter character outside parameter phase");
`endif

endmodule

// ===== rtl/core/fcp_queue.sv =====
module fcp_queue import fcp_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	output logic             valid,
	output logic [WIDTH-1:0] rdata,
	input  logic             pop
);

	logic [WIDTH-1:0]     mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full  = (count_q == (QPTR_BITS + 1)'(QDEPTH));
	assign valid = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/core/fcp_back.sv =====
module fcp_back import fcp_pkg::*; #(
	parameter int MAX_VERB_CHARS   = 5,
	parameter int PARAM_COUNT_BITS = 12,
	parameter int VCW              = $clog2(MAX_VERB_CHARS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              pop,
	input  fcp_item_t                         item,
	input  logic [PARAM_COUNT_BITS-1:0]       len,
	input  logic [MAX_VERB_CHARS-1:0][7:0]    verb,
	input  logic [VCW-1:0]                    vcnt,
	input  logic                              ovl,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              is_verdict,
	output logic [7:0]                        param_char,
	output logic [5:0]                        command_code,
	output logic [1:0]                        status,
	output logic [PARAM_COUNT_BITS-1:0]       param_length
);

	logic                        out_valid_q;
	logic                        is_verdict_q;
	logic [7:0]                  param_char_q;
	logic [5:0]                  code_q;
	logic [1:0]                  status_q;
	logic [PARAM_COUNT_BITS-1:0] len_q;
	logic [5:0]                  code_d;

	assign pop = q_valid && (!out_valid_q || out_ready);

	// table match, case folded on a-z only
	always_comb begin
		logic [NAME_CHARS-1:0][7:0] fold;
		logic                       hit;
		logic [5:0]                 code;
		code = CMD_UNKNOWN;
		for (int i = 0; i < NAME_CHARS; i++) begin
			fold[i] = verb[i];
			if (verb[i] >= "a" && verb[i] <= "z") fold[i] = verb[i] - 8'd32;
		end
		for (int k = NUM_CMDS - 1; k >= 0; k--) begin
			hit = (vcnt == VCW'(CMD_LEN[k]));
			for (int i = 0; i < NAME_CHARS; i++) begin
				if ((3'(i) < CMD_LEN[k]) &&
				    (fold[i] != CMD_NAME[k][8*(NAME_CHARS-i)-1 -: 8])) hit = 1'b0;
			end
			if (hit) code = 6'(k + 1);
		end
		code_d = (item.lookup && !ovl) ? code : CMD_UNKNOWN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_verdict_q <= item.is_verdict;
			param_char_q <= item.ch;
			code_q       <= code_d;
			status_q     <= item.status;
			len_q        <= len;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_verdict   = is_verdict_q;
	assign param_char   = param_char_q;
	assign command_code = code_q;
	assign status       = status_q;
	assign param_length = len_q;

`ifndef NO_ASSERTIONS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !pop) else $error("queue popped while output stalled");
`endif

endmodule
